/* rtl/core/vsal_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Version check package
// Character codes, limits and helper functions shared by the version
// string checker.
// ----------------------------------------------------------------------------
package vsal_pkg;

   // Width of one version part and of each required-version register.
   localparam int PART_W = 17;

   // Largest value that a version part may take.
   localparam logic [PART_W-1:0] PART_LIMIT = 17'd100000;

   // Characters with a meaning in the string.
   localparam logic [7:0] CHAR_LOWER_V = 8'h76;
   localparam logic [7:0] CHAR_UPPER_V = 8'h56;
   localparam logic [7:0] CHAR_DOT     = 8'h2E;
   localparam logic [7:0] CHAR_DASH    = 8'h2D;
   localparam logic [7:0] CHAR_ZERO    = 8'h30;
   localparam logic [7:0] CHAR_NINE    = 8'h39;

   // Length of the "dirty" suffix and the code for a suffix that cannot match.
   localparam logic [2:0] DIRTY_LEN  = 3'd5;
   localparam logic [2:0] DIRTY_DEAD = 3'd7;

   // Register indexes of the configuration port.
   localparam logic [1:0] CSR_MAJOR = 2'd0;
   localparam logic [1:0] CSR_MINOR = 2'd1;
   localparam logic [1:0] CSR_PATCH = 2'd2;

   // True for the bytes '0' to '9'.
   function automatic logic is_digit(input logic [7:0] c);
      return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
   endfunction

   // Expected character at a given position of the word "dirty".
   function automatic logic [7:0] dirty_char(input logic [2:0] pos);
      logic [7:0] ch;
      case (pos)
         3'd0:    ch = 8'h64;
         3'd1:    ch = 8'h69;
         3'd2:    ch = 8'h72;
         3'd3:    ch = 8'h74;
         3'd4:    ch = 8'h79;
         default: ch = 8'h00;
      endcase
      return ch;
   endfunction

endpackage
`default_nettype wire

/* rtl/core/version_string_at_least.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Version string checker
// Parses a streamed version string and tells whether it is at least the
// configured major.minor.patch.
// ----------------------------------------------------------------------------
// One character is taken per item, and a new item can be accepted in every
// clock cycle while req_stall is low. Each item passes through an input
// register and is parsed there; the answer enters the result register and
// rsp_valid rises at the same edge at which the last item leaves the input
// register. Only the item marked last produces a result item. While a result
// is held back by rsp_stall, a last item behind it waits in the input
// register and req_stall is raised; other items keep moving. The user must
// write the required version through the csr_ port only while no string is
// in flight; the block does not enforce it. A write to index 3 has no effect.
module version_string_at_least (
   input  wire                          clock,
   input  wire                          reset,
   // Configuration port
   input  wire                          csr_write,
   input  wire  [1:0]                   csr_index,
   input  wire  [vsal_pkg::PART_W-1:0]  csr_wdata,
   // Input channel
   input  wire                          req_valid,
   output logic                         req_stall,
   input  wire  [7:0]                   req_symbol,
   input  wire                          req_has_symbol,
   input  wire                          req_last,
   // Result channel
   output logic                         rsp_valid,
   input  wire                          rsp_stall,
   output logic                         rsp_at_least
);
   import vsal_pkg::*;

   // Parser phases.
   localparam logic [1:0] PH_START      = 2'd0;
   localparam logic [1:0] PH_PART_FIRST = 2'd1;
   localparam logic [1:0] PH_IN_PART    = 2'd2;
   localparam logic [1:0] PH_SUFFIX     = 2'd3;

   // Outcome of the part comparison so far.
   localparam logic [1:0] CMP_EQ = 2'd0;
   localparam logic [1:0] CMP_GT = 2'd1;
   localparam logic [1:0] CMP_LT = 2'd2;

   // Required version registers.
   logic [PART_W-1:0] major_ff, minor_ff, patch_ff;

   // Input register.
   logic              s1_valid_ff;
   logic [7:0]        s1_symbol_ff;
   logic              s1_has_ff;
   logic              s1_last_ff;

   // Parser state.
   logic [1:0]        phase_ff, phase_in;
   logic [1:0]        part_index_ff, part_index_in;
   logic [PART_W-1:0] part_value_ff, part_value_in;
   logic [1:0]        cmp_ff, cmp_in;
   logic              decided_ff, decided_in;
   logic              decided_value_ff, decided_value_in;
   logic [2:0]        dirty_ff, dirty_in;
   logic              sfx_digit_ff, sfx_digit_in;
   logic              sfx_only_ff, sfx_only_in;

   // Result register.
   logic              rsp_valid_ff;
   logic              rsp_at_least_ff;

   // Working signals of the parse step.
   logic              s1_advance;
   logic              s1_fire;
   logic              req_take;
   logic              rsp_take;
   logic              consume;
   logic              sym_digit;
   logic [20:0]       scaled;
   logic [PART_W-1:0] req_cur;
   logic [PART_W-1:0] req_nx;
   logic [1:0]        cmp_done;
   logic [1:0]        cmp_final;
   logic              answer;

   // Selects the required part for a part index.
   function automatic logic [PART_W-1:0] pick_req(input logic [1:0] idx,
                                                  input logic [PART_W-1:0] ma,
                                                  input logic [PART_W-1:0] mi,
                                                  input logic [PART_W-1:0] pa);
      logic [PART_W-1:0] r;
      case (idx)
         2'd0:    r = ma;
         2'd1:    r = mi;
         default: r = pa;
      endcase
      return r;
   endfunction

   // Folds one finished part into the comparison outcome.
   function automatic logic [1:0] fold_cmp(input logic [1:0] st,
                                           input logic [PART_W-1:0] val,
                                           input logic [PART_W-1:0] req);
      logic [1:0] r;
      r = st;
      if (st == CMP_EQ) begin
         if (val > req) begin
            r = CMP_GT;
         end else if (val < req) begin
            r = CMP_LT;
         end
      end
      return r;
   endfunction

   // Handshake control: the input register moves on unless it holds a last
   // item whose result cannot yet enter the result register.
   assign rsp_take   = rsp_valid_ff && !rsp_stall;
   assign s1_advance = !s1_last_ff || !rsp_valid_ff || !rsp_stall;
   assign s1_fire    = s1_valid_ff && s1_advance;
   assign req_stall  = s1_valid_ff && !s1_advance;
   assign req_take   = req_valid && !req_stall;

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_at_least = rsp_at_least_ff;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         major_ff <= '0;
         minor_ff <= '0;
         patch_ff <= '0;
      end else if (csr_write) begin
         case (csr_index)
            CSR_MAJOR: major_ff <= csr_wdata;
            CSR_MINOR: minor_ff <= csr_wdata;
            CSR_PATCH: patch_ff <= csr_wdata;
            default:   ;
         endcase
      end
   end

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_take) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_fire) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_symbol_ff <= req_symbol;
         s1_has_ff    <= req_has_symbol;
         s1_last_ff   <= req_last;
      end
   end

   // Digit arithmetic for the current character.
   assign sym_digit = is_digit(s1_symbol_ff);
   assign scaled    = ({4'b0, part_value_ff} << 3) + ({4'b0, part_value_ff} << 1)
                    + {17'b0, s1_symbol_ff[3:0]};
   assign req_cur   = pick_req(part_index_ff, major_ff, minor_ff, patch_ff);
   assign cmp_done  = fold_cmp(cmp_ff, part_value_ff, req_cur);

   // Parse step: next parser state after the character in the input register.
   always_comb begin
      phase_in         = phase_ff;
      part_index_in    = part_index_ff;
      part_value_in    = part_value_ff;
      cmp_in           = cmp_ff;
      decided_in       = decided_ff;
      decided_value_in = decided_value_ff;
      dirty_in         = dirty_ff;
      sfx_digit_in     = sfx_digit_ff;
      sfx_only_in      = sfx_only_ff;
      consume          = 1'b1;
      if (s1_has_ff && !decided_ff) begin
         if (phase_ff == PH_START) begin
            phase_in = PH_PART_FIRST;
            if (s1_symbol_ff == CHAR_LOWER_V || s1_symbol_ff == CHAR_UPPER_V) begin
               consume = 1'b0;
            end
         end
         if (consume) begin
            case (phase_ff)
               PH_START, PH_PART_FIRST: begin
                  if (!sym_digit) begin
                     decided_in       = 1'b1;
                     decided_value_in = 1'b0;
                  end else begin
                     part_value_in = {13'b0, s1_symbol_ff[3:0]};
                     phase_in      = PH_IN_PART;
                  end
               end
               PH_IN_PART: begin
                  if (sym_digit) begin
                     if (scaled > {4'b0, PART_LIMIT}) begin
                        decided_in       = 1'b1;
                        decided_value_in = 1'b0;
                     end else begin
                        part_value_in = scaled[PART_W-1:0];
                     end
                  end else begin
                     cmp_in = cmp_done;
                     if (part_index_ff < 2'd2) begin
                        if (s1_symbol_ff != CHAR_DOT) begin
                           decided_in       = 1'b1;
                           decided_value_in = 1'b0;
                        end else begin
                           part_index_in = part_index_ff + 2'd1;
                           part_value_in = '0;
                           phase_in      = PH_PART_FIRST;
                        end
                     end else if (cmp_done != CMP_EQ) begin
                        decided_in       = 1'b1;
                        decided_value_in = (cmp_done == CMP_GT);
                     end else if (s1_symbol_ff != CHAR_DASH) begin
                        decided_in       = 1'b1;
                        decided_value_in = 1'b0;
                     end else begin
                        phase_in = PH_SUFFIX;
                     end
                  end
               end
               PH_SUFFIX: begin
                  if (s1_symbol_ff == CHAR_DASH) begin
                     decided_in       = 1'b1;
                     decided_value_in = sfx_digit_ff && sfx_only_ff;
                  end else begin
                     if (sym_digit) begin
                        sfx_digit_in = 1'b1;
                     end else begin
                        sfx_only_in = 1'b0;
                     end
                     if (dirty_ff < DIRTY_LEN && s1_symbol_ff == dirty_char(dirty_ff)) begin
                        dirty_in = dirty_ff + 3'd1;
                     end else begin
                        dirty_in = DIRTY_DEAD;
                     end
                  end
               end
               default: ;
            endcase
         end
      end
   end

   // Answer for a last item, taken from the state after its character.
   assign req_nx    = pick_req(part_index_in, major_ff, minor_ff, patch_ff);
   assign cmp_final = fold_cmp(cmp_in, part_value_in, req_nx);

   always_comb begin
      if (decided_in) begin
         answer = decided_value_in;
      end else begin
         case (phase_in)
            PH_IN_PART: answer = (part_index_in == 2'd2) && (cmp_final != CMP_LT);
            PH_SUFFIX:  answer = (dirty_in == DIRTY_LEN);
            default:    answer = 1'b0;
         endcase
      end
   end

   // Parser state registers; the end of a string returns them to reset.
   always_ff @(posedge clock) begin
      if (reset || (s1_fire && s1_last_ff)) begin
         phase_ff         <= PH_START;
         part_index_ff    <= 2'd0;
         part_value_ff    <= '0;
         cmp_ff           <= CMP_EQ;
         decided_ff       <= 1'b0;
         decided_value_ff <= 1'b0;
         dirty_ff         <= 3'd0;
         sfx_digit_ff     <= 1'b0;
         sfx_only_ff      <= 1'b1;
      end else if (s1_fire) begin
         phase_ff         <= phase_in;
         part_index_ff    <= part_index_in;
         part_value_ff    <= part_value_in;
         cmp_ff           <= cmp_in;
         decided_ff       <= decided_in;
         decided_value_ff <= decided_value_in;
         dirty_ff         <= dirty_in;
         sfx_digit_ff     <= sfx_digit_in;
         sfx_only_ff      <= sfx_only_in;
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_fire && s1_last_ff) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_take) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_fire && s1_last_ff) begin
         rsp_at_least_ff <= answer;
      end
   end

`ifndef NO_ASSERTIONS
   // The end of a string leaves the parser in its starting state.
   assert property (@(posedge clock) disable iff (reset)
      s1_fire && s1_last_ff |=> phase_ff == PH_START && !decided_ff && part_index_ff == 2'd0)
      else $error("parser state not cleared after the last item");

   // A fixed answer stays fixed until the string ends.
   assert property (@(posedge clock) disable iff (reset)
      decided_ff && !(s1_fire && s1_last_ff) |=> decided_ff && $stable(decided_value_ff))
      else $error("decided answer changed within a string");

   // A stored part never exceeds the limit.
   assert property (@(posedge clock) disable iff (reset)
      part_value_ff <= PART_LIMIT)
      else $error("version part above the limit was stored");

   // The suffix matcher is either on the word or dead.
   assert property (@(posedge clock) disable iff (reset)
      dirty_ff <= DIRTY_LEN || dirty_ff == DIRTY_DEAD)
      else $error("suffix match count out of range");

   // A last item never overwrites a result that has not been taken.
   assert property (@(posedge clock) disable iff (reset)
      s1_fire && s1_last_ff |-> !rsp_valid_ff || rsp_take)
      else $error("result register overwritten");
`endif

endmodule
`default_nettype wire

/* tb/tb_version_string_at_least.sv */
// ----------------------------------------------------------------------------
// Version string checker testbench
// Streams version strings into the checker under a series of required
// versions and compares every answer with a cycle-free behavioural model or
// the answer a table row gives. A short table of hand-picked strings comes
// first, then random strings, most of them well formed and close to the
// required version. The input channel idles and the result channel stalls at random.
// ----------------------------------------------------------------------------
module tb_version_string_at_least;

   localparam int PW = vsal_pkg::PART_W;

   // Run shape
   localparam int ITEM_TARGET   = 1650;
   localparam int PHASE_ITEMS   = 120;
   localparam int SETTLE_CYCLES = 6;
   localparam int QUIET_LIMIT   = 1000;
   localparam int NO_GAP_AT     = -1;

   // Unused register index; a write there must change nothing.
   localparam logic [1:0] CSR_SPARE = 2'd3;

   // Characters that steer the parse.
   localparam logic [7:0] CH_V_LOWER = 8'h76;
   localparam logic [7:0] CH_V_UPPER = 8'h56;
   localparam logic [7:0] CH_DOT     = 8'h2E;
   localparam logic [7:0] CH_DASH    = 8'h2D;
   localparam logic [7:0] CH_ZERO    = 8'h30;
   localparam logic [7:0] CH_NINE    = 8'h39;

   localparam int unsigned VALUE_CAP    = 100000;
   localparam logic [39:0] DIRTY_WORD   = "dirty";
   localparam int unsigned DIRTY_FULL   = 5;
   localparam int unsigned DIRTY_BROKEN = 7;

   // How a table row gets its expected answer.
   localparam logic [1:0] ANS_NO    = 2'd0;
   localparam logic [1:0] ANS_YES   = 2'd1;
   localparam logic [1:0] ANS_MODEL = 2'd2;

   localparam logic [8:0] NO_TAIL = 9'h000;
   localparam logic [3:0] NO_GAP  = 4'hF;

   typedef enum logic [1:0] {
      SCAN_START, SCAN_PART_HEAD, SCAN_PART_BODY, SCAN_SUFFIX
   } scan_type;

   typedef enum logic [1:0] {
      ORDER_EQUAL, ORDER_ABOVE, ORDER_BELOW
   } order_type;

   // One directed string: text, optional extra byte, position of an empty
   // item, whether the string ends on an item without a byte, and answer.
   typedef struct packed {
      logic [8*12-1:0] text;
      logic [8:0]      tail;
      logic [3:0]      gap_at;
      logic            bare_end;
      logic [1:0]      answer;
   } probe_type;

   probe_type probe_rows [0:8] = '{
      '{"",       NO_TAIL,        NO_GAP, 1'b1, ANS_NO},    // empty string
      '{"",       {1'b1, 8'h00},  NO_GAP, 1'b0, ANS_NO},    // lowest byte alone
      '{"v0.0.0", NO_TAIL,        4'd2,   1'b0, ANS_YES},   // empty item inside
      '{"0.0.0",  {1'b1, 8'hFF},  NO_GAP, 1'b0, ANS_NO},    // highest byte after the patch
      '{"1.2",    NO_TAIL,        NO_GAP, 1'b1, ANS_NO},    // patch missing
      '{"100001", NO_TAIL,        NO_GAP, 1'b0, ANS_NO},    // part over the cap
      '{"1.0.0x", NO_TAIL,        NO_GAP, 1'b0, ANS_YES},   // greater, suffix ignored
      '{"V9:",    NO_TAIL,        NO_GAP, 1'b0, ANS_NO},    // byte just past '9'
      '{"3.2.1",  NO_TAIL,        NO_GAP, 1'b1, ANS_MODEL}
   };

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          csr_write = 1'b0;
   logic [1:0]    csr_index = '0;
   logic [PW-1:0] csr_wdata = '0;
   logic          req_valid = 1'b0;
   logic          req_stall;
   logic [7:0]    req_symbol = '0;
   logic          req_has_symbol = 1'b0;
   logic          req_last = 1'b0;
   logic          rsp_valid;
   logic          rsp_stall = 1'b0;
   logic          rsp_at_least;

   // Required version as the model sees it.
   logic [PW-1:0] want_major, want_minor, want_patch;

   // Parse state of the model.
   scan_type    scan;
   order_type   order;
   int unsigned part_no;
   int unsigned part_acc;
   int unsigned dirty_pos;
   bit          settled;
   bit          settled_value;
   bit          sfx_digit_seen;
   bit          sfx_all_digits;

   // Answers still owed by the checker, oldest first.
   bit          verdicts_due [$];
   logic [7:0]  text_q [$];

   int  mismatches = 0;
   int  items_sent = 0;
   int  strings_sent = 0;
   int  answers_true = 0;
   int  answers_false = 0;
   int  phase_no = 0;
   int  quiet = 0;
   int  rsp_hold = 0;
   int  next_hold;
   bit  tx_eager = 1'b0;
   bit  rx_eager = 1'b0;

   version_string_at_least uut (
      .clock          (clock),
      .reset          (reset),
      .csr_write      (csr_write),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_symbol     (req_symbol),
      .req_has_symbol (req_has_symbol),
      .req_last       (req_last),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_at_least   (rsp_at_least)
   );

   always #5 clock = ~clock;

   // ------------------------------------------------------------------------
   // Behavioural model
   // ------------------------------------------------------------------------

   function automatic bit is_decimal(input logic [7:0] c);
      return (c >= CH_ZERO) && (c <= CH_NINE);
   endfunction

   function automatic void clear_scan();
      scan           = SCAN_START;
      order          = ORDER_EQUAL;
      part_no        = 0;
      part_acc       = 0;
      dirty_pos      = 0;
      settled        = 1'b0;
      settled_value  = 1'b0;
      sfx_digit_seen = 1'b0;
      sfx_all_digits = 1'b1;
   endfunction

   function automatic void settle(input bit v);
      settled       = 1'b1;
      settled_value = v;
   endfunction

   // Fold the finished part into the running comparison.
   function automatic void close_part();
      logic [PW-1:0] goal;
      goal = (part_no == 0) ? want_major : (part_no == 1) ? want_minor : want_patch;
      if (order == ORDER_EQUAL) begin
         if (part_acc > goal)
            order = ORDER_ABOVE;
         else if (part_acc < goal)
            order = ORDER_BELOW;
      end
   endfunction

   function automatic void absorb_byte(input logic [7:0] c);
      int unsigned grown;
      if (settled)
         return;
      // One leading v or V is skipped.
      if (scan == SCAN_START) begin
         scan = SCAN_PART_HEAD;
         if (c == CH_V_LOWER || c == CH_V_UPPER)
            return;
      end
      case (scan)
         SCAN_PART_HEAD: begin
            if (!is_decimal(c))
               settle(1'b0);
            else begin
               part_acc = 32'(c - CH_ZERO);
               scan     = SCAN_PART_BODY;
            end
         end
         SCAN_PART_BODY: begin
            if (is_decimal(c)) begin
               grown = part_acc * 10 + 32'(c - CH_ZERO);
               if (grown > VALUE_CAP)
                  settle(1'b0);
               else
                  part_acc = grown;
            end else begin
               close_part();
               if (part_no < 2) begin
                  if (c != CH_DOT)
                     settle(1'b0);
                  else begin
                     part_no++;
                     part_acc = 0;
                     scan     = SCAN_PART_HEAD;
                  end
               end else if (order != ORDER_EQUAL)
                  settle(order == ORDER_ABOVE);
               else if (c != CH_DASH)
                  settle(1'b0);
               else
                  scan = SCAN_SUFFIX;
            end
         end
         default: begin
            // Inside the suffix that follows the first dash.
            if (c == CH_DASH)
               settle(sfx_digit_seen && sfx_all_digits);
            else begin
               if (is_decimal(c))
                  sfx_digit_seen = 1'b1;
               else
                  sfx_all_digits = 1'b0;
               if (dirty_pos < DIRTY_FULL && c == DIRTY_WORD[8*(4-dirty_pos) +: 8])
                  dirty_pos++;
               else
                  dirty_pos = DIRTY_BROKEN;
            end
         end
      endcase
   endfunction

   function automatic bit closing_answer();
      if (settled)
         return settled_value;
      if (scan == SCAN_PART_BODY) begin
         if (part_no < 2)
            return 1'b0;
         close_part();
         return order != ORDER_BELOW;
      end
      if (scan == SCAN_SUFFIX)
         return dirty_pos == DIRTY_FULL;
      return 1'b0;
   endfunction

   // Advance the model by one item; the answer is meaningful on the last one.
   function automatic bit model_item(input logic [7:0] sym, input bit has, input bit fin);
      bit answer;
      answer = 1'b0;
      if (has)
         absorb_byte(sym);
      if (fin) begin
         answer = closing_answer();
         clear_scan();
      end
      return answer;
   endfunction

   // ------------------------------------------------------------------------
   // String generation
   // ------------------------------------------------------------------------

   // Half the time a byte with a meaning to the parser, otherwise any byte.
   function automatic logic [7:0] jumble_byte();
      string pool;
      pool = "0123456789.-vV/:dirtyx";
      if ($urandom_range(0, 1) == 0)
         return pool[$urandom_range(0, pool.len() - 1)];
      return 8'($urandom_range(0, 255));
   endfunction

   // A part value, usually equal to the required one so that suffixes matter.
   function automatic int unsigned near_value(input logic [PW-1:0] goal);
      int unsigned pick;
      pick = $urandom_range(0, 9);
      if (pick <= 6)
         return 32'(goal);
      if (pick == 7)
         return 32'(goal) + 1;
      if (pick == 8)
         return (goal == 0) ? 0 : 32'(goal) - 1;
      return ($urandom_range(0, 2) == 0) ? VALUE_CAP + 1 : $urandom_range(0, VALUE_CAP);
   endfunction

   function automatic string part_text(input int unsigned v);
      string s;
      s = $sformatf("%0d", v);
      if ($urandom_range(0, 9) == 0)
         s = {"0", s};
      return s;
   endfunction

   function automatic string suffix_text();
      string s;
      int    pick;
      pick = $urandom_range(0, 9);
      s = "";
      if (pick == 2 || pick == 3)
         s = "-dirty";
      else if (pick == 4 || pick == 5) begin
         // Dash, digits, dash, then anything.
         s = "-";
         repeat ($urandom_range(1, 3)) s = $sformatf("%s%0d", s, $urandom_range(0, 9));
         s = {s, "-"};
         repeat ($urandom_range(0, 2)) s = $sformatf("%s%c", s, $urandom_range(33, 126));
      end else if (pick == 6) begin
         case ($urandom_range(0, 4))
            0:       s = "-dirt";
            1:       s = "-dirtyy";
            2:       s = "-dirty-";
            3:       s = "-Dirty";
            default: s = "-d1rty";
         endcase
      end else if (pick == 7) begin
         s = "-";
         repeat ($urandom_range(1, 3)) s = $sformatf("%s%0d", s, $urandom_range(0, 9));
      end else if (pick == 8)
         s = ($urandom_range(0, 1) == 0) ? "--" : "-4x-";
      else if (pick == 9)
         s = $sformatf("%c", $urandom_range(33, 126));
      return s;
   endfunction

   function automatic string version_text();
      string s;
      case ($urandom_range(0, 3))
         0:       s = "v";
         1:       s = "V";
         default: s = "";
      endcase
      return {s, part_text(near_value(want_major)), ".", part_text(near_value(want_minor)),
              ".", part_text(near_value(want_patch)), suffix_text()};
   endfunction

   // Fill text_q with a well-formed, damaged or noise string.
   task automatic compose_random();
      string s;
      int    kind;
      int    keep;
      text_q.delete();
      kind = $urandom_range(0, 19);
      if (kind < 17) begin
         s = version_text();
         for (int i = 0; i < s.len(); i++) text_q.insert(text_q.size(), s[i]);
         // Damaged: cut short or one byte overwritten.
         if (kind >= 14) begin
            if ($urandom_range(0, 1) == 0) begin
               keep = $urandom_range(0, text_q.size() - 1);
               while (text_q.size() > keep) void'(text_q.pop_back());
            end else
               text_q[$urandom_range(0, text_q.size() - 1)] = jumble_byte();
         end
      end else begin
         repeat ($urandom_range(0, 8)) text_q.insert(text_q.size(), jumble_byte());
      end
   endtask

   // ------------------------------------------------------------------------
   // Driving
   // ------------------------------------------------------------------------

   // Offer one item and wait until it is taken; returns the model's answer.
   task automatic push_item(input logic [7:0] sym, input bit has, input bit fin,
                            output bit verdict);
      int pause;
      pause = tx_eager ? 0 : $urandom_range(0, 12);
      if (pause != 0) begin
         req_valid <= 1'b0;
         repeat (pause) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_symbol     <= sym;
      req_has_symbol <= has;
      req_last       <= fin;
      do @(posedge clock); while (req_stall);
      verdict = model_item(sym, has, fin);
      if (has || fin)
         items_sent++;
   endtask

   // Send text_q as one string and queue the answer it is owed.
   task automatic feed_string(input bit bare_end, input int gap_at, input logic [1:0] answer);
      bit verdict;
      int n;
      n = text_q.size();
      for (int i = 0; i < n; i++) begin
         if (i == gap_at)
            push_item(8'($urandom_range(0, 255)), 1'b0, 1'b0, verdict);
         push_item(text_q[i], 1'b1, !bare_end && (i == n - 1), verdict);
      end
      if (bare_end)
         push_item(8'($urandom_range(0, 255)), 1'b0, 1'b1, verdict);
      if (answer == ANS_MODEL)
         verdicts_due.insert(verdicts_due.size(), verdict);
      else
         verdicts_due.insert(verdicts_due.size(), answer == ANS_YES);
      strings_sent++;
   endtask

   // Let every owed answer arrive and the pipeline empty.
   task automatic drain();
      req_valid <= 1'b0;
      while (verdicts_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic program_version(input logic [PW-1:0] maj, input logic [PW-1:0] mnr,
                                  input logic [PW-1:0] pat);
      csr_write <= 1'b1;
      csr_index <= CSR_SPARE;
      csr_wdata <= PW'($urandom_range(0, (1 << PW) - 1));
      @(posedge clock);
      csr_index <= vsal_pkg::CSR_MAJOR;
      csr_wdata <= maj;
      @(posedge clock);
      want_major = maj;
      csr_index <= vsal_pkg::CSR_MINOR;
      csr_wdata <= mnr;
      @(posedge clock);
      want_minor = mnr;
      csr_index <= vsal_pkg::CSR_PATCH;
      csr_wdata <= pat;
      @(posedge clock);
      want_patch = pat;
      csr_write <= 1'b0;
   endtask

   function automatic logic [PW-1:0] pick_requirement();
      int pick;
      pick = $urandom_range(0, 19);
      if (pick < 12)
         return PW'($urandom_range(0, 12));
      if (pick < 17)
         return PW'($urandom_range(0, VALUE_CAP));
      if (pick < 19)
         return PW'(VALUE_CAP);
      return PW'($urandom_range(VALUE_CAP + 1, (1 << PW) - 1));
   endfunction

   // ------------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------------
   initial begin
      probe_type     row;
      logic [7:0]    ch;
      logic [PW-1:0] maj, mnr, pat;
      int            phase_start;
      int            gap;
      bit            bare;

      want_major = '0;
      want_minor = '0;
      want_patch = '0;
      clear_scan();
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Hand-picked strings under the reset requirement of 0.0.0.
      for (int r = 0; r < 9; r++) begin
         row = probe_rows[r];
         text_q.delete();
         for (int b = 11; b >= 0; b--) begin
            ch = row.text[8*b +: 8];
            if (ch != 8'h00)
               text_q.insert(text_q.size(), ch);
         end
         if (row.tail[8])
            text_q.insert(text_q.size(), row.tail[7:0]);
         gap = (row.gap_at == NO_GAP) ? NO_GAP_AT : row.gap_at;
         feed_string(row.bare_end, gap, row.answer);
      end

      // Random strings under a series of required versions.
      while (items_sent < ITEM_TARGET) begin
         case (phase_no)
            0: begin maj = PW'(VALUE_CAP); mnr = PW'(VALUE_CAP); pat = PW'(VALUE_CAP); end
            1: begin maj = '1; mnr = '1; pat = '1; end
            2: begin maj = '0; mnr = '0; pat = '0; end
            3: begin maj = PW'(1); mnr = PW'(2); pat = PW'(3); end
            default: begin
               maj = pick_requirement();
               mnr = pick_requirement();
               pat = pick_requirement();
            end
         endcase
         drain();
         program_version(maj, mnr, pat);
         rx_eager <= ($urandom_range(0, 3) == 0);
         phase_start = items_sent;
         while (items_sent - phase_start < PHASE_ITEMS) begin
            tx_eager = ($urandom_range(0, 4) == 0);
            compose_random();
            bare = (text_q.size() == 0) || ($urandom_range(0, 3) == 0);
            gap  = (text_q.size() != 0 && $urandom_range(0, 7) == 0) ?
                   $urandom_range(0, text_q.size() - 1) : NO_GAP_AT;
            feed_string(bare, gap, ANS_MODEL);
         end
         phase_no++;
      end

      drain();
      $display("Checked %0d version strings (%0d items) under %0d required versions.",
               strings_sent, items_sent, phase_no + 1);
      $display("Answers seen: %0d at least, %0d below.", answers_true, answers_false);
      if (mismatches == 0 && verdicts_due.size() == 0)
         $display("** version_string_at_least: PASSED **");
      else
         $display("** version_string_at_least: FAILED **");
      $finish;
   end

   // ------------------------------------------------------------------------
   // Result checking and receiver stalls
   // ------------------------------------------------------------------------

   // Once a result item is taken, rsp_stall holds off the next for a drawn hold.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (verdicts_due.size() == 0) begin
            $error("at_least: no answer expected, actual %0b", rsp_at_least);
            mismatches++;
         end else begin
            if (rsp_at_least !== verdicts_due[0]) begin
               $error("at_least: expected %0b, actual %0b", verdicts_due[0], rsp_at_least);
               mismatches++;
            end
            void'(verdicts_due.pop_front());
         end
         if (rsp_at_least === 1'b1)
            answers_true++;
         else
            answers_false++;
         next_hold = rx_eager ? 0 : $urandom_range(0, 12);
         rsp_hold  <= next_hold;
         rsp_stall <= (next_hold != 0);
      end else if (!reset && rsp_valid && rsp_stall) begin
         rsp_hold  <= rsp_hold - 1;
         rsp_stall <= (rsp_hold > 1);
      end
   end

   // Watchdog: too long without any item moving ends the run.
   always @(posedge clock) begin
      if (reset || csr_write || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet <= 0;
      else
         quiet <= quiet + 1;
      if (quiet == QUIET_LIMIT) begin
         $display("Timeout: nothing accepted for %0d cycles.", QUIET_LIMIT);
         $display("** version_string_at_least: FAILED **");
         $finish;
      end
   end

endmodule
